FILE: sv/tbcs_pkg.sv
`default_nettype none

package tbcs_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int CNT_W    = 12;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [2:0] {
    MODE_CLOCK  = 3'd0,
    MODE_HOUR   = 3'd1,
    MODE_MINUTE = 3'd2,
    MODE_SECOND = 3'd3,
    MODE_DATE   = 3'd4,
    MODE_YEAR   = 3'd5,
    MODE_MONTH  = 3'd6,
    MODE_DAY    = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS      = 4'd0,
    CFG_REPEAT_DELAY    = 4'd1,
    CFG_REPEAT_INTERVAL = 4'd2,
    CFG_DATE_SHOW       = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_delay_ticks;
    logic [CNT_W-1:0] repeat_interval_ticks;
    logic [CNT_W-1:0] date_show_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic                button_one;
    logic                button_two;
    logic                second_pulse;
    logic [HOUR_W-1:0]   clock_hour;
    logic [MINUTE_W-1:0] clock_minute;
    logic [SECOND_W-1:0] clock_second;
    logic [YEAR_W-1:0]   clock_year;
    logic [MONTH_W-1:0]  clock_month;
    logic [DAY_W-1:0]    clock_day;
  } in_item_t;

  typedef struct packed {
    mode_t               ui_mode;
    logic [HOUR_W-1:0]   shown_hour;
    logic [MINUTE_W-1:0] shown_minute;
    logic [SECOND_W-1:0] shown_second;
    logic [YEAR_W-1:0]   shown_year;
    logic [MONTH_W-1:0]  shown_month;
    logic [DAY_W-1:0]    shown_day;
    logic                format_24h;
    logic                blink_allowed;
    logic                save_time;
    logic                save_date;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/tbcs_in_if.sv
`default_nettype none

interface tbcs_in_if;
  import tbcs_pkg::*;

  logic                valid;
  logic                ready;
  logic                button_one;
  logic                button_two;
  logic                second_pulse;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINUTE_W-1:0] clock_minute;
  logic [SECOND_W-1:0] clock_second;
  logic [YEAR_W-1:0]   clock_year;
  logic [MONTH_W-1:0]  clock_month;
  logic [DAY_W-1:0]    clock_day;

  modport source (
    output valid, button_one, button_two, second_pulse, clock_hour, clock_minute,
           clock_second, clock_year, clock_month, clock_day,
    input  ready
  );

  modport sink (
    input  valid, button_one, button_two, second_pulse, clock_hour, clock_minute,
           clock_second, clock_year, clock_month, clock_day,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/tbcs_out_if.sv
`default_nettype none

interface tbcs_out_if;
  import tbcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          ui_mode;
  logic [HOUR_W-1:0]   shown_hour;
  logic [MINUTE_W-1:0] shown_minute;
  logic [SECOND_W-1:0] shown_second;
  logic [YEAR_W-1:0]   shown_year;
  logic [MONTH_W-1:0]  shown_month;
  logic [DAY_W-1:0]    shown_day;
  logic                format_24h;
  logic                blink_allowed;
  logic                save_time;
  logic                save_date;

  modport source (
    output valid, ui_mode, shown_hour, shown_minute, shown_second, shown_year,
           shown_month, shown_day, format_24h, blink_allowed, save_time, save_date,
    input  ready
  );

  modport sink (
    input  valid, ui_mode, shown_hour, shown_minute, shown_second, shown_year,
           shown_month, shown_day, format_24h, blink_allowed, save_time, save_date,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/tbcs_cfg_if.sv
`default_nettype none

interface tbcs_cfg_if;
  import tbcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/tbcs_cfg.sv
`default_nettype none

module tbcs_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  tbcs_cfg_if.sink          cfg_ch,
  output tbcs_pkg::cfg_regs_t regs
);
  import tbcs_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LONG_PRESS:      regs_nxt.long_press_ticks      = cfg_ch.data;
        CFG_REPEAT_DELAY:    regs_nxt.repeat_delay_ticks    = cfg_ch.data;
        CFG_REPEAT_INTERVAL: regs_nxt.repeat_interval_ticks = cfg_ch.data;
        CFG_DATE_SHOW:       regs_nxt.date_show_ticks       = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.long_press_ticks      <= 12'd2000;
      regs_r.repeat_delay_ticks    <= 12'd500;
      regs_r.repeat_interval_ticks <= 12'd100;
      regs_r.date_show_ticks       <= 12'd2000;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tbcs_core.sv
`default_nettype none

module tbcs_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  tbcs_pkg::in_item_t   item,
  input  tbcs_pkg::cfg_regs_t  regs,
  output tbcs_pkg::out_item_t  res
);
  import tbcs_pkg::*;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } fields_t;

  typedef struct packed {
    mode_t            ui_state;
    mode_t            prev_ui_state;
    logic             prev_one;
    logic             prev_two;
    logic [CNT_W-1:0] both_hold_count;
    logic [CNT_W-1:0] date_hold_count;
    logic [CNT_W-1:0] date_show_count;
    logic [CNT_W-1:0] two_hold_count;
    logic [CNT_W-1:0] repeat_count;
    logic             await_release;
    logic             skip_one_release;
    logic             skip_two_release;
    logic             is_format_24;
    logic             blink_flag;
    fields_t          f;
  } core_state_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // one increment of the field the mode edits, wrapping by compare-subtract
  function automatic fields_t bump_field(input mode_t m, input fields_t fi);
    fields_t          fo;
    logic [5:0]       th;
    logic [6:0]       tm;
    logic [6:0]       ts;
    logic [7:0]       ty;
    logic [MONTH_W-1:0] rm;
    logic [DAY_W-1:0] md;
    logic [DAY_W-1:0] rd;
    fo = fi;
    th = {1'b0, fi.hour} + 6'd1;
    tm = {1'b0, fi.minute} + 7'd1;
    ts = {1'b0, fi.second} + 7'd1;
    ty = {1'b0, fi.year} + 8'd1;
    rm = (fi.month >= 4'd12) ? fi.month - 4'd12 : fi.month;
    md = month_days(fi.month, fi.year);
    rd = (fi.day >= md) ? fi.day - md : fi.day;
    case (m)
      MODE_HOUR: begin
        if (th >= 6'd24) th = th - 6'd24;
        fo.hour = th[HOUR_W-1:0];
      end
      MODE_MINUTE: begin
        if (tm >= 7'd60) tm = tm - 7'd60;
        fo.minute = tm[MINUTE_W-1:0];
      end
      MODE_SECOND: begin
        if (ts >= 7'd60) ts = ts - 7'd60;
        fo.second = ts[SECOND_W-1:0];
      end
      MODE_YEAR: begin
        if (ty >= 8'd100) ty = ty - 8'd100;
        fo.year = ty[YEAR_W-1:0];
      end
      MODE_MONTH: fo.month = rm + 4'd1;
      MODE_DAY:   fo.day = rd + 5'd1;
      default: ;
    endcase
    return fo;
  endfunction

  core_state_t state_r;
  core_state_t state_nxt;
  logic        st;
  logic        sd;

  always_comb begin
    core_state_t      s;
    logic             b1;
    logic             b2;
    logic             frozen;
    logic [DAY_W-1:0] md;
    s      = state_r;
    b1     = item.button_one;
    b2     = item.button_two;
    frozen = 1'b0;
    st     = 1'b0;
    sd     = 1'b0;
    md     = '0;

    unique case (state_r.ui_state)
      MODE_CLOCK: begin
        if (b1 && b2 && s.prev_one && s.prev_two) begin
          s.both_hold_count = s.both_hold_count + 12'd1;
          if (s.both_hold_count >= regs.long_press_ticks) begin
            s.ui_state         = MODE_HOUR;
            s.both_hold_count  = '0;
            s.await_release    = 1'b1;
            s.skip_one_release = 1'b1;
            s.skip_two_release = 1'b1;
            s.f.hour   = item.clock_hour;
            s.f.minute = item.clock_minute;
            s.f.second = item.clock_second;
          end
        end else begin
          s.both_hold_count = '0;
          if (!b1 && s.prev_one && !b2) s.is_format_24 = ~s.is_format_24;
          if (!b2 && s.prev_two && !b1) begin
            s.ui_state        = MODE_DATE;
            s.date_show_count = regs.date_show_ticks;
            s.f.year  = item.clock_year;
            s.f.month = item.clock_month;
            s.f.day   = item.clock_day;
          end
        end
      end
      MODE_DATE: begin
        if (b2 && s.prev_two) begin
          s.date_hold_count = s.date_hold_count + 12'd1;
          if (s.date_hold_count >= regs.long_press_ticks) begin
            s.ui_state         = MODE_YEAR;
            s.date_hold_count  = '0;
            s.await_release    = 1'b1;
            s.skip_one_release = 1'b1;
            s.skip_two_release = 1'b1;
            s.f.year  = item.clock_year;
            s.f.month = item.clock_month;
            s.f.day   = item.clock_day;
          end
        end else begin
          s.date_hold_count = '0;
        end
        if (!b2 && !s.prev_two) begin
          if (s.date_show_count != '0) s.date_show_count = s.date_show_count - 12'd1;
          if (s.date_show_count == '0) s.ui_state = MODE_CLOCK;
        end
      end
      default: begin
        if (s.await_release) begin
          // hold the edge history until both buttons are up
          if (!b1 && !b2) s.await_release = 1'b0;
          frozen = 1'b1;
        end else begin
          if (!b1 && s.prev_one && !s.skip_one_release) begin
            if (s.ui_state == MODE_SECOND || s.ui_state == MODE_DAY) begin
              if (s.prev_ui_state >= MODE_HOUR && s.prev_ui_state <= MODE_SECOND) begin
                if (s.f.hour > 5'd23)   s.f.hour = '0;
                if (s.f.minute > 6'd59) s.f.minute = '0;
                if (s.f.second > 6'd59) s.f.second = '0;
                st = 1'b1;
              end else if (s.prev_ui_state >= MODE_YEAR) begin
                if (s.f.year > 7'd99) s.f.year = '0;
                if (s.f.month < 4'd1 || s.f.month > 4'd12) s.f.month = 4'd1;
                md = month_days(s.f.month, s.f.year);
                if (s.f.day < 5'd1 || s.f.day > md) s.f.day = md;
                sd = 1'b1;
              end
              s.ui_state         = MODE_CLOCK;
              s.await_release    = 1'b1;
              s.skip_one_release = 1'b1;
              s.skip_two_release = 1'b1;
            end else begin
              s.ui_state = mode_t'(s.ui_state + 3'd1);
            end
            s.two_hold_count = '0;
          end
          if (!b1 && s.prev_one) s.skip_one_release = 1'b0;

          if (!s.await_release) begin
            if (!b2 && s.prev_two && !s.skip_two_release) s.f = bump_field(s.ui_state, s.f);
            if (b2) begin
              if (s.two_hold_count != {CNT_W{1'b1}}) s.two_hold_count = s.two_hold_count + 12'd1;
              if (s.two_hold_count >= regs.repeat_delay_ticks) begin
                s.repeat_count = s.repeat_count + 12'd1;
                if (s.repeat_count >= regs.repeat_interval_ticks) begin
                  s.f = bump_field(s.ui_state, s.f);
                  s.repeat_count = '0;
                end
              end
            end else begin
              s.two_hold_count = '0;
              s.repeat_count   = '0;
            end
            if (!b2 && s.prev_two) s.skip_two_release = 1'b0;
          end
          s.blink_flag = !b2 && (s.two_hold_count < regs.repeat_delay_ticks);
        end
      end
    endcase

    if (!frozen) begin
      s.prev_one      = b1;
      s.prev_two      = b2;
      s.prev_ui_state = s.ui_state;
    end

    // track the chip time only while the display is in normal mode
    if (item.second_pulse && s.ui_state == MODE_CLOCK && !st && !sd) begin
      s.f.hour   = item.clock_hour;
      s.f.minute = item.clock_minute;
      s.f.second = item.clock_second;
    end

    state_nxt = s;
  end

  always_comb begin
    res.ui_mode       = state_nxt.ui_state;
    res.shown_hour    = state_nxt.f.hour;
    res.shown_minute  = state_nxt.f.minute;
    res.shown_second  = state_nxt.f.second;
    res.shown_year    = state_nxt.f.year;
    res.shown_month   = state_nxt.f.month;
    res.shown_day     = state_nxt.f.day;
    res.format_24h    = state_nxt.is_format_24;
    res.blink_allowed = state_nxt.blink_flag;
    res.save_time     = st;
    res.save_date     = sd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.ui_state         <= MODE_CLOCK;
      state_r.prev_ui_state    <= MODE_CLOCK;
      state_r.prev_one         <= 1'b0;
      state_r.prev_two         <= 1'b0;
      state_r.both_hold_count  <= '0;
      state_r.date_hold_count  <= '0;
      state_r.date_show_count  <= '0;
      state_r.two_hold_count   <= '0;
      state_r.repeat_count     <= '0;
      state_r.await_release    <= 1'b0;
      state_r.skip_one_release <= 1'b0;
      state_r.skip_two_release <= 1'b0;
      state_r.is_format_24     <= 1'b1;
      state_r.blink_flag       <= 1'b1;
      state_r.f.hour           <= 5'd12;
      state_r.f.minute         <= 6'd34;
      state_r.f.second         <= 6'd36;
      state_r.f.year           <= 7'd25;
      state_r.f.month          <= 4'd6;
      state_r.f.day            <= 5'd9;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  a_single_save: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(res.save_time && res.save_date))
    else $error("time and date saved on the same tick");

  a_save_returns_normal: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.save_time || res.save_date)
      |=> state_r.ui_state == MODE_CLOCK && state_r.await_release)
    else $error("save did not return to normal mode awaiting release");

  a_frozen_history: assert property (@(posedge clk) disable iff (!rst_n)
    step && state_r.await_release && item.button_one
      && state_r.ui_state != MODE_CLOCK && state_r.ui_state != MODE_DATE
      |=> $stable(state_r.prev_one) && $stable(state_r.prev_two)
          && $stable(state_r.prev_ui_state))
    else $error("edge history moved while awaiting release");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(state_r))
    else $error("state changed without an item");

endmodule

`default_nettype wire

FILE: sv/two_button_clock_set_controller.sv
`default_nettype none
// Channel   | Role  | Handshake        | Payload
// in_ch     | sink  | valid/ready      | button levels, second pulse, chip time and date
// out_ch    | source| valid/ready      | mode, shown time and date, format, blink, saves
// cfg_ch    | sink  | valid/ready      | register index, 12-bit write data
//
// Each tick request is registered in the input register and then in the
// result register; one request per cycle is sustained while out_ch is not stalled.
// The step logic between the two registers sets the clock period.
// A stalled result register holds its request; the input register takes a
// new request only while it is empty and holds it until the result register frees.
// Synchronous active-low reset restores the documented time, date and thresholds.
module two_button_clock_set_controller (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tbcs_in_if.sink    in_ch,
  tbcs_out_if.source out_ch,
  tbcs_cfg_if.sink   cfg_ch
);
  import tbcs_pkg::*;

  cfg_regs_t regs;
  in_item_t  in_item_r;
  logic      in_v_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      out_v_r;
  logic      advance;

  // advance the held request once the result register can take it
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  tbcs_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  tbcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .regs  (regs),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.button_one   <= in_ch.button_one;
      in_item_r.button_two   <= in_ch.button_two;
      in_item_r.second_pulse <= in_ch.second_pulse;
      in_item_r.clock_hour   <= in_ch.clock_hour;
      in_item_r.clock_minute <= in_ch.clock_minute;
      in_item_r.clock_second <= in_ch.clock_second;
      in_item_r.clock_year   <= in_ch.clock_year;
      in_item_r.clock_month  <= in_ch.clock_month;
      in_item_r.clock_day    <= in_ch.clock_day;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.ui_mode       = out_item_r.ui_mode;
  assign out_ch.shown_hour    = out_item_r.shown_hour;
  assign out_ch.shown_minute  = out_item_r.shown_minute;
  assign out_ch.shown_second  = out_item_r.shown_second;
  assign out_ch.shown_year    = out_item_r.shown_year;
  assign out_ch.shown_month   = out_item_r.shown_month;
  assign out_ch.shown_day     = out_item_r.shown_day;
  assign out_ch.format_24h    = out_item_r.format_24h;
  assign out_ch.blink_allowed = out_item_r.blink_allowed;
  assign out_ch.save_time     = out_item_r.save_time;
  assign out_ch.save_date     = out_item_r.save_date;

endmodule

`default_nettype wire
